/* design/dbl_pkg.sv */
// Shared types and constants for the decimal byte list parser.
`default_nettype none
package dbl_pkg;

    localparam int MAX_BYTES_DEF = 4096;
    localparam int ACC_W         = 9;
    localparam int BYTE_CNT_W    = 13;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;

    localparam logic [ACC_W-1:0] ACC_SAT  = 9'd256;
    localparam logic [ACC_W-1:0] BYTE_MAX = 9'd255;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_EMPTY,
        PH_SPACE,
        PH_SIGN,
        PH_DIGITS,
        PH_TRAIL
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [ACC_W-1:0]   acc;
        logic               neg;
        logic               digit_seen;
        logic               err;
        logic               nul;
    } dbl_state_t;

    typedef struct packed {
        logic                  byte_valid;
        logic [7:0]            byte_value;
        logic                  done_res;
        logic                  parse_error;
        logic [BYTE_CNT_W-1:0] byte_count;
    } dbl_result_t;

endpackage
`default_nettype wire

/* design/dbl_step.sv */
// One-character parser step: next state, next count and the result item.
`default_nettype none
module dbl_step #(
    parameter int MAX_BYTES = dbl_pkg::MAX_BYTES_DEF,
    parameter int CNT_W     = $clog2(MAX_BYTES + 1)
) (
    input  wire logic [7:0]       text_char,
    input  wire logic             last,
    input  wire dbl_pkg::dbl_state_t st,
    input  wire logic [CNT_W-1:0] count,
    output dbl_pkg::dbl_state_t   st_next,
    output logic [CNT_W-1:0]      count_next,
    output logic                  has_result,
    output dbl_pkg::dbl_result_t  result
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BYTES);

    logic              is_bracket;
    logic              is_space;
    logic              is_digit;
    logic [3:0]        digit;
    logic [11:0]       acc_sum;
    logic [dbl_pkg::ACC_W-1:0] acc_dig;
    logic              fin_tok;
    logic              tok_ok;
    logic              emit;
    logic [7:0]        val;
    dbl_pkg::dbl_state_t s;

    always_comb begin
        is_bracket = (text_char == dbl_pkg::CHAR_LT) || (text_char == dbl_pkg::CHAR_GT);
        is_space   = (text_char == dbl_pkg::CHAR_SPACE) ||
                     ((text_char >= dbl_pkg::CHAR_TAB) && (text_char <= dbl_pkg::CHAR_CR));
        is_digit   = (text_char >= dbl_pkg::CHAR_ZERO) && (text_char <= dbl_pkg::CHAR_NINE);
        digit      = 4'(text_char - dbl_pkg::CHAR_ZERO);
        acc_sum    = {3'b000, st.acc} * 12'd10 + {8'h00, digit};
        acc_dig    = (acc_sum > {3'b000, dbl_pkg::ACC_SAT}) ? dbl_pkg::ACC_SAT
                                                           : acc_sum[dbl_pkg::ACC_W-1:0];

        s       = st;
        fin_tok = 1'b0;

        if (!st.err && !st.nul) begin
            if (s.phase == dbl_pkg::PH_LEAD && !is_bracket) begin
                s.phase = dbl_pkg::PH_EMPTY;
            end
            case (s.phase)
                dbl_pkg::PH_LEAD: begin
                end
                dbl_pkg::PH_EMPTY, dbl_pkg::PH_SPACE: begin
                    if (is_space) begin
                        s.phase = dbl_pkg::PH_SPACE;
                    end else if (text_char == dbl_pkg::CHAR_PLUS ||
                                 text_char == dbl_pkg::CHAR_MINUS) begin
                        s.neg   = (text_char == dbl_pkg::CHAR_MINUS);
                        s.phase = dbl_pkg::PH_SIGN;
                    end else if (is_digit) begin
                        s.acc        = acc_dig;
                        s.digit_seen = 1'b1;
                        s.phase      = dbl_pkg::PH_DIGITS;
                    end else if (text_char == dbl_pkg::CHAR_NUL &&
                                 s.phase == dbl_pkg::PH_EMPTY) begin
                        s.nul = 1'b1;
                    end else if (is_bracket && s.phase == dbl_pkg::PH_EMPTY) begin
                        s.phase = dbl_pkg::PH_TRAIL;
                    end else begin
                        s.err = 1'b1;
                    end
                end
                dbl_pkg::PH_SIGN: begin
                    if (is_digit) begin
                        s.acc        = acc_dig;
                        s.digit_seen = 1'b1;
                        s.phase      = dbl_pkg::PH_DIGITS;
                    end else begin
                        s.err = 1'b1;
                    end
                end
                dbl_pkg::PH_DIGITS: begin
                    if (is_digit) begin
                        s.acc        = acc_dig;
                        s.digit_seen = 1'b1;
                    end else if (text_char == dbl_pkg::CHAR_COMMA) begin
                        fin_tok = 1'b1;
                    end else if (text_char == dbl_pkg::CHAR_NUL) begin
                        fin_tok = 1'b1;
                        s.nul   = 1'b1;
                    end else if (is_bracket) begin
                        s.phase = dbl_pkg::PH_TRAIL;
                    end else begin
                        s.err = 1'b1;
                    end
                end
                default: begin
                    if (!is_bracket) begin
                        s.err = 1'b1;
                    end
                end
            endcase
        end

        // End of string closes an open token, or flags a dangling sign or space.
        if (last && !fin_tok && !s.err && !s.nul) begin
            if (s.phase == dbl_pkg::PH_DIGITS ||
                (s.phase == dbl_pkg::PH_TRAIL && s.digit_seen)) begin
                fin_tok = 1'b1;
            end else if (s.phase == dbl_pkg::PH_SPACE || s.phase == dbl_pkg::PH_SIGN) begin
                s.err = 1'b1;
            end
        end

        tok_ok     = !(s.neg && s.acc != '0) && (s.acc <= dbl_pkg::BYTE_MAX) &&
                     (count < MAX_CNT);
        emit       = fin_tok && tok_ok;
        val        = s.acc[7:0];
        count_next = count;
        if (fin_tok) begin
            s.acc        = '0;
            s.neg        = 1'b0;
            s.digit_seen = 1'b0;
            s.phase      = dbl_pkg::PH_EMPTY;
            if (tok_ok) begin
                count_next = count + CNT_W'(1);
            end else begin
                s.err = 1'b1;
            end
        end

        has_result         = emit || last;
        result.byte_valid  = emit;
        result.byte_value  = emit ? val : 8'h00;
        result.done_res    = last;
        result.parse_error = s.err;
        result.byte_count  = dbl_pkg::BYTE_CNT_W'(count_next);

        // Return to the reset state after the last character of a string.
        if (last) begin
            s.phase      = dbl_pkg::PH_LEAD;
            s.acc        = '0;
            s.neg        = 1'b0;
            s.digit_seen = 1'b0;
            s.err        = 1'b0;
            s.nul        = 1'b0;
            count_next   = '0;
        end
        st_next = s;
    end

endmodule
`default_nettype wire

/* design/decimal_byte_list_parser.sv */
// Top level of the decimal byte list parser: stream ports, state and output buffer.
//
// Usage: feed the text of a term such as <<24,1,240>> one character per item on
// the s_ channel, s_tdata holding the character and s_tlast marking the final
// character of the string. A result item leaves on the m_ channel whenever a
// valid byte token completes (at a comma, a NUL or the end of the string) and always
// for the final character; other characters give no result.
// Output: a result is registered in the result register, or in the skid register
// while the result register is held, and is presented on m_tvalid from there.
// Throughput: one character per cycle while s_tready is high. The per-character
// work is a single accumulate-by-ten and a few compares in dbl_step, between the
// state registers and the result register.
// Stalls: a two-entry output buffer (result register plus skid register) lets
// the block keep accepting while one result waits; s_tready drops only when
// both entries are full.
// Reset: aresetn (synchronous, active low) returns the parser to the leading
// bracket skip with zero count and no error, and empties the output buffer.
// After the final character of each string the parser state returns to reset.
// Error and byte count are reported per string; errors are sticky within it.
`default_nettype none
module decimal_byte_list_parser #(
    parameter int MAX_BYTES = dbl_pkg::MAX_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_char
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] byte_value, [8] parse_error,
                                        // [21:9] byte_count, [23:22] zero
    output logic             m_tuser,   // byte_valid
    output logic             m_tlast    // done_res
);

    localparam int CNT_W = $clog2(MAX_BYTES + 1);

    dbl_pkg::dbl_state_t  st_reg;
    dbl_pkg::dbl_state_t  st_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 has_result;
    dbl_pkg::dbl_result_t result;

    dbl_pkg::dbl_result_t out_reg;
    logic                 out_valid_reg;
    dbl_pkg::dbl_result_t skid_reg;
    logic                 skid_valid_reg;

    logic                 accept;
    logic                 pop;
    logic                 push;

    dbl_step #(
        .MAX_BYTES (MAX_BYTES),
        .CNT_W     (CNT_W)
    ) u_step (
        .text_char  (s_tdata),
        .last       (s_tlast),
        .st         (st_reg),
        .count      (count_reg),
        .st_next    (st_next),
        .count_next (count_next),
        .has_result (has_result),
        .result     (result)
    );

    // Take a character whenever the skid entry is free.
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign push     = accept && has_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase      <= dbl_pkg::PH_LEAD;
            st_reg.acc        <= '0;
            st_reg.neg        <= 1'b0;
            st_reg.digit_seen <= 1'b0;
            st_reg.err        <= 1'b0;
            st_reg.nul        <= 1'b0;
            count_reg         <= '0;
        end else if (accept) begin
            st_reg    <= st_next;
            count_reg <= count_next;
        end
    end

    // Output buffer: drain skid into the result register first, else load new results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_reg       <= result;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= result;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.byte_count, out_reg.parse_error, out_reg.byte_value};
    assign m_tuser  = out_reg.byte_valid;
    assign m_tlast  = out_reg.done_res;

endmodule
`default_nettype wire
